FILE: design/ptts_pkg.sv
// Shared types and command/status codes for the priority task table scheduler.
package ptts_pkg;

	typedef enum logic [2:0] {
		CMD_CLEAR = 3'd0,
		CMD_ADD   = 3'd1,
		CMD_WRITE = 3'd2,
		CMD_NEXT  = 3'd3,
		CMD_FIND  = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_FULL = 2'd1,
		ST_MISS = 2'd2
	} status_t;

	localparam int unsigned ID_W   = 8;
	localparam int unsigned PRIO_W = 8;
	localparam int unsigned EV_W   = 16;

	typedef struct packed {
		logic              valid;
		logic [ID_W-1:0]   id;
		logic [PRIO_W-1:0] prio;
		logic [EV_W-1:0]   events;
	} entry_t;

	// Broadcast to every cell in the row.
	typedef struct packed {
		logic              go;
		logic              add_ok;
		cmd_t              cmd;
		logic [ID_W-1:0]   id;
		logic [PRIO_W-1:0] prio;
		logic [EV_W-1:0]   events;
	} ctl_t;

endpackage

FILE: design/ptts_cell.sv
// One table slot: holds an entry, takes its left neighbor's entry on insert.
module ptts_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  ptts_pkg::ctl_t  ctl,
	input  ptts_pkg::entry_t left,
	input  logic            left_shift,
	input  logic            wr_sel,
	output ptts_pkg::entry_t ent,
	output logic            shift,
	output logic            id_hit,
	output logic            ready_hit
);
	import ptts_pkg::*;

	entry_t ent_q;
	entry_t ent_nxt;

	assign ent       = ent_q;
	// An occupied slot with lower priority moves one place right on insert.
	assign shift     = ent_q.valid && (ctl.prio > ent_q.prio);
	assign id_hit    = ent_q.valid && (ent_q.id == ctl.id);
	assign ready_hit = ent_q.valid && (ent_q.events != '0);

	always_comb begin
		ent_nxt = ent_q;
		if (ctl.go) begin
			unique case (ctl.cmd)
				CMD_CLEAR: begin
					ent_nxt.valid = 1'b0;
				end
				CMD_ADD: begin
					if (ctl.add_ok) begin
						if (left_shift) begin
							ent_nxt = left;
						end else if (shift || (!ent_q.valid && left.valid)) begin
							ent_nxt.valid  = 1'b1;
							ent_nxt.id     = ctl.id;
							ent_nxt.prio   = ctl.prio;
							ent_nxt.events = '0;
						end
					end
				end
				CMD_WRITE: begin
					if (wr_sel) begin
						ent_nxt.events = ctl.events;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_q <= '0;
		end else begin
			ent_q <= ent_nxt;
		end
	end

endmodule

FILE: design/priority_task_table_scheduler_core.sv
// Top level of the priority task table scheduler: a row of table cells and a result register.
//
// The block keeps up to MAX_TASKS tasks (id, priority, pending event bits) in a
// row of cells, packed from cell 0 in descending priority, ties in insertion
// order. Each accepted command transfer (clear, add, write events, next ready,
// find) takes effect at the edge that accepts it: every cell compares its entry
// against the command at once, an insert moves each lower-priority entry one
// cell right in the same edge, and searches pick the first hit in table order.
// One result transfer leaves for each command, from a single output register
// loaded at acceptance. A new command is taken in every cycle in which that
// register is empty or its result is being taken, so the rate is one command
// per clock while the downstream side keeps m_tready high. Status codes are
// 0 ok, 1 table full on add, 2 no entry found; the reported entry fields are
// zero whenever no entry is reported. An add into a full table is refused and
// leaves the table untouched.
module priority_task_table_scheduler_core #(
	parameter int unsigned MAX_TASKS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	// command transfer
	input  logic        s_tvalid,
	output logic        s_tready,
	// [2:0] command, [10:3] task_id, [18:11] priority_req, [34:19] event_bits,
	// [39:35] zero
	input  logic [39:0] s_tdata,
	// result transfer
	output logic        m_tvalid,
	input  logic        m_tready,
	// [1:0] status, [9:2] found_id, [17:10] found_priority, [33:18] found_events,
	// [39:34] zero
	output logic [39:0] m_tdata
);
	import ptts_pkg::*;

	ctl_t                 ctl;
	logic                 accept;
	entry_t               ents      [MAX_TASKS];
	entry_t               lefts     [MAX_TASKS];
	logic [MAX_TASKS-1:0] shifts;
	logic [MAX_TASKS-1:0] left_shifts;
	logic [MAX_TASKS-1:0] id_hits;
	logic [MAX_TASKS-1:0] ready_hits;
	logic [MAX_TASKS-1:0] valid_vec;
	logic [MAX_TASKS-1:0] hit_vec;
	logic [MAX_TASKS-1:0] first_hit;
	entry_t               picked;
	logic                 found;

	status_t              status_d;
	entry_t               report_d;

	logic                 out_valid_q;
	status_t              status_q;
	logic [ID_W-1:0]      found_id_q;
	logic [PRIO_W-1:0]    found_prio_q;
	logic [EV_W-1:0]      found_ev_q;

	// Take a new command whenever the result register is free or draining.
	assign s_tready = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	// Broadcast the command to the row.
	always_comb begin
		ctl.go     = accept;
		ctl.cmd    = cmd_t'(s_tdata[2:0]);
		ctl.id     = s_tdata[10:3];
		ctl.prio   = s_tdata[18:11];
		ctl.events = s_tdata[34:19];
		// Refuse the insert when the last cell is occupied.
		ctl.add_ok = !valid_vec[MAX_TASKS-1];
	end

	genvar gi;
	generate
		for (gi = 0; gi < MAX_TASKS; gi++) begin : g_cell
			if (gi == 0) begin : g_head
				// Cell 0 sees an occupied, non-shifting neighbor so an empty
				// table loads the new entry here.
				always_comb begin
					lefts[gi]       = '0;
					lefts[gi].valid = 1'b1;
					left_shifts[gi] = 1'b0;
				end
			end else begin : g_body
				always_comb begin
					lefts[gi]       = ents[gi-1];
					left_shifts[gi] = shifts[gi-1];
				end
			end

			ptts_cell u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.ctl        (ctl),
				.left       (lefts[gi]),
				.left_shift (left_shifts[gi]),
				.wr_sel     (first_hit[gi]),
				.ent        (ents[gi]),
				.shift      (shifts[gi]),
				.id_hit     (id_hits[gi]),
				.ready_hit  (ready_hits[gi])
			);

			assign valid_vec[gi] = ents[gi].valid;
		end
	endgenerate

	// Isolate the first hit in table order.
	assign hit_vec   = (ctl.cmd == CMD_NEXT) ? ready_hits : id_hits;
	assign first_hit = hit_vec & (~hit_vec + {{(MAX_TASKS-1){1'b0}}, 1'b1});
	assign found     = |hit_vec;

	// One-hot select of the hit entry.
	always_comb begin
		picked = '0;
		for (int i = 0; i < MAX_TASKS; i++) begin
			picked = picked | (first_hit[i] ? ents[i] : '0);
		end
	end

	// Form the result.
	always_comb begin
		status_d = ST_OK;
		report_d = '0;
		unique case (ctl.cmd)
			CMD_ADD: begin
				if (!ctl.add_ok) begin
					status_d = ST_FULL;
				end
			end
			CMD_WRITE: begin
				if (found) begin
					report_d        = picked;
					report_d.events = ctl.events;
				end else begin
					status_d = ST_MISS;
				end
			end
			CMD_NEXT, CMD_FIND: begin
				if (found) begin
					report_d = picked;
				end else begin
					status_d = ST_MISS;
				end
			end
			default: begin
			end
		endcase
	end

	// Hold the result until the downstream side takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q     <= status_d;
			found_id_q   <= report_d.id;
			found_prio_q <= report_d.prio;
			found_ev_q   <= report_d.events;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'd0, found_ev_q, found_prio_q, found_id_q, status_q};

	// Occupied cells always form a run starting at cell 0.
	a_packed: assert property (@(posedge clk) disable iff (!arst_n)
		((valid_vec + {{(MAX_TASKS-1){1'b0}}, 1'b1}) & valid_vec) == '0)
		else $error("table entries not packed");

	a_first_hit: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(first_hit))
		else $error("more than one search hit selected");

	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (ctl.cmd == CMD_CLEAR) |=> valid_vec == '0)
		else $error("table not empty after clear");

	a_full_hold: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (ctl.cmd == CMD_ADD) && valid_vec[MAX_TASKS-1]
		|=> $stable(valid_vec) && (status_q == ST_FULL))
		else $error("add into full table changed the table");

	a_add_grow: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (ctl.cmd == CMD_ADD) && !valid_vec[MAX_TASKS-1]
		|=> $countones(valid_vec) == $countones($past(valid_vec)) + 1)
		else $error("add did not occupy exactly one more cell");

endmodule

FILE: tb/sv/priority_task_table_scheduler_core_tb.sv
// Self-checking testbench for the priority task table scheduler core.
module priority_task_table_scheduler_core_tb;
	import ptts_pkg::*;

	localparam int unsigned MAX_TASKS    = 8;
	localparam int unsigned RANDOM_ITEMS = 1350;
	localparam int unsigned IDLE_LIMIT   = 2000;
	localparam int unsigned DRAIN_CYCLES = 8;
	localparam int unsigned DIR_ROWS     = 25;

	// Command codes the block ignores; they still return one ok result.
	localparam logic [2:0] CMD_RSVD5 = 3'd5;
	localparam logic [2:0] CMD_RSVD6 = 3'd6;
	localparam logic [2:0] CMD_RSVD7 = 3'd7;

	// One command as it travels on s_tdata.
	typedef struct packed {
		logic [2:0]        command;
		logic [ID_W-1:0]   task_id;
		logic [PRIO_W-1:0] prio;
		logic [EV_W-1:0]   events;
	} task_cmd_t;

	// One result as it travels on m_tdata.
	typedef struct packed {
		logic [1:0]        status;
		logic [ID_W-1:0]   id;
		logic [PRIO_W-1:0] prio;
		logic [EV_W-1:0]   events;
	} task_reply_t;

	// Directed row: when typed is set, the result is known by inspection and the
	// found fields are all zero; otherwise the table model supplies it.
	typedef struct {
		task_cmd_t  cmd;
		bit         typed;
		logic [1:0] status;
	} dir_row_t;

	logic        clk;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	// [2:0] command, [10:3] task_id, [18:11] priority_req, [34:19] event_bits,
	// [39:35] zero
	logic [39:0] s_tdata  = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	// [1:0] status, [9:2] found_id, [17:10] found_priority, [33:18] found_events,
	// [39:34] zero
	logic [39:0] m_tdata;

	// Mirror of the task table, slot 0 first.
	entry_t      task_table [MAX_TASKS];
	// Results owed by the block, oldest first.
	task_reply_t pending_replies [$];

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int mismatches     = 0;
	int idle_cycles    = 0;

	// Walk empty-table misses, extremes of every field, priority ties, duplicate
	// ids, the full-table refusal, event rewrite to zero, unused codes and clear.
	dir_row_t directed_rows [DIR_ROWS] = '{
		'{'{CMD_FIND,  8'h00, 8'h00, 16'h0000}, 1'b1, ST_MISS},
		'{'{CMD_NEXT,  8'h00, 8'h00, 16'h0000}, 1'b1, ST_MISS},
		'{'{CMD_WRITE, 8'hFF, 8'hFF, 16'hFFFF}, 1'b1, ST_MISS},
		'{'{CMD_ADD,   8'h00, 8'h00, 16'hFFFF}, 1'b1, ST_OK},
		'{'{CMD_ADD,   8'hFF, 8'hFF, 16'h0000}, 1'b1, ST_OK},
		'{'{CMD_ADD,   8'h12, 8'h80, 16'h0000}, 1'b1, ST_OK},
		'{'{CMD_ADD,   8'h12, 8'h80, 16'h0000}, 1'b1, ST_OK},
		'{'{CMD_ADD,   8'h34, 8'h00, 16'h0000}, 1'b1, ST_OK},
		'{'{CMD_ADD,   8'hA5, 8'hFF, 16'h0000}, 1'b1, ST_OK},
		'{'{CMD_ADD,   8'h5A, 8'h01, 16'h0000}, 1'b1, ST_OK},
		'{'{CMD_ADD,   8'h77, 8'h80, 16'h0000}, 1'b1, ST_OK},
		'{'{CMD_ADD,   8'h99, 8'hFF, 16'h0000}, 1'b1, ST_FULL},
		'{'{CMD_NEXT,  8'h00, 8'h00, 16'h0000}, 1'b1, ST_MISS},
		'{'{CMD_WRITE, 8'h12, 8'h00, 16'hFFFF}, 1'b0, ST_OK},
		'{'{CMD_WRITE, 8'h00, 8'h00, 16'h0001}, 1'b0, ST_OK},
		'{'{CMD_NEXT,  8'h00, 8'h00, 16'h0000}, 1'b0, ST_OK},
		'{'{CMD_FIND,  8'h12, 8'h00, 16'h0000}, 1'b0, ST_OK},
		'{'{CMD_WRITE, 8'h12, 8'h00, 16'h0000}, 1'b0, ST_OK},
		'{'{CMD_NEXT,  8'h00, 8'h00, 16'h0000}, 1'b0, ST_OK},
		'{'{CMD_FIND,  8'h34, 8'h00, 16'h0000}, 1'b0, ST_OK},
		'{'{CMD_RSVD5, 8'h12, 8'h80, 16'h0000}, 1'b1, ST_OK},
		'{'{CMD_RSVD6, 8'h00, 8'h00, 16'h0000}, 1'b1, ST_OK},
		'{'{CMD_RSVD7, 8'hFF, 8'hFF, 16'hFFFF}, 1'b1, ST_OK},
		'{'{CMD_CLEAR, 8'hFF, 8'hFF, 16'hFFFF}, 1'b1, ST_OK},
		'{'{CMD_FIND,  8'hFF, 8'h00, 16'h0000}, 1'b1, ST_MISS}
	};

	priority_task_table_scheduler_core #(
		.MAX_TASKS(MAX_TASKS)
	) u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Apply one command to the table mirror and return the result it owes.
	function automatic task_reply_t run_table_cmd(task_cmd_t cmd);
		task_reply_t r;
		int          hit;
		int          fill;
		int          pos;
		r   = '0;
		hit = -1;
		case (cmd.command)
			CMD_CLEAR: begin
				foreach (task_table[i]) task_table[i] = '0;
			end
			CMD_ADD: begin
				fill = 0;
				while (fill < MAX_TASKS && task_table[fill].valid) fill++;
				if (fill >= MAX_TASKS) begin
					// Refuse the add, leave the table as it is.
					r.status = ST_FULL;
				end else begin
					// Insert ahead of the first strictly lower priority, else at the tail.
					pos = fill;
					for (int i = 0; i < fill; i++)
						if (pos == fill && cmd.prio > task_table[i].prio) pos = i;
					for (int i = fill; i > pos; i--) task_table[i] = task_table[i - 1];
					task_table[pos].valid  = 1'b1;
					task_table[pos].id     = cmd.task_id;
					task_table[pos].prio   = cmd.prio;
					task_table[pos].events = '0;
				end
			end
			CMD_WRITE, CMD_FIND: begin
				for (int i = 0; i < MAX_TASKS; i++)
					if (hit < 0 && task_table[i].valid && task_table[i].id == cmd.task_id) hit = i;
				if (hit >= 0 && cmd.command == CMD_WRITE) task_table[hit].events = cmd.events;
			end
			CMD_NEXT: begin
				for (int i = 0; i < MAX_TASKS; i++)
					if (hit < 0 && task_table[i].valid && task_table[i].events != '0) hit = i;
			end
			default: ;
		endcase
		if (cmd.command inside {CMD_WRITE, CMD_NEXT, CMD_FIND}) begin
			if (hit < 0) begin
				r.status = ST_MISS;
			end else begin
				r.status = ST_OK;
				r.id     = task_table[hit].id;
				r.prio   = task_table[hit].prio;
				r.events = task_table[hit].events;
			end
		end
		return r;
	endfunction

	// Mostly well-formed traffic on a small id pool so that writes and finds hit,
	// with enough adds to fill the table and rare clears to empty it again.
	function automatic task_cmd_t random_task_cmd();
		task_cmd_t cmd;
		int        pick;
		pick        = $urandom_range(0, 99);
		cmd.task_id = ($urandom_range(0, 7) == 0) ? ID_W'($urandom_range(0, 255))
		                                          : ID_W'($urandom_range(0, 11));
		cmd.prio    = ($urandom_range(0, 1) == 0) ? PRIO_W'($urandom_range(0, 3))
		                                          : PRIO_W'($urandom_range(0, 255));
		cmd.events  = ($urandom_range(0, 3) == 0) ? '0 : EV_W'($urandom_range(0, 65535));
		if (pick < 3)       cmd.command = CMD_CLEAR;
		else if (pick < 33) cmd.command = CMD_ADD;
		else if (pick < 58) cmd.command = CMD_WRITE;
		else if (pick < 73) cmd.command = CMD_NEXT;
		else if (pick < 96) cmd.command = CMD_FIND;
		else begin
			case ($urandom_range(0, 2))
				0:       cmd.command = CMD_RSVD5;
				1:       cmd.command = CMD_RSVD6;
				default: cmd.command = CMD_RSVD7;
			endcase
		end
		return cmd;
	endfunction

	// Offer one command transfer. Called at a rising edge; returns at the edge
	// that accepts it, so the next call can hold tvalid high without a gap.
	task automatic send_task_cmd(task_cmd_t cmd, bit typed, logic [1:0] typed_status);
		task_reply_t r;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {5'b0, cmd.events, cmd.prio, cmd.task_id, cmd.command};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		r = run_table_cmd(cmd);
		if (typed) begin
			r        = '0;
			r.status = typed_status;
		end
		pending_replies.push_back(r);
	endtask

	task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
		if (want !== got) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
		end
	endtask

	// Result side: check each accepted transfer against the oldest owed result,
	// then pick the ready level for the next edge.
	initial begin
		task_reply_t want;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				if (pending_replies.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected result, expected none, actual %0h", $time, m_tdata);
				end else begin
					want = pending_replies.pop_front();
					check_field("status", 16'(want.status), 16'(m_tdata[1:0]));
					check_field("found_id", 16'(want.id), 16'(m_tdata[9:2]));
					check_field("found_priority", 16'(want.prio), 16'(m_tdata[17:10]));
					check_field("found_events", want.events, m_tdata[33:18]);
				end
			end
			m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// Watchdog: end the run when no transfer moves on either side for too long.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("** priority_task_table_scheduler_core: FAILED **");
				$finish;
			end
		end
	end

	initial begin
		foreach (task_table[i]) task_table[i] = '0;
		// Hold reset, then release it on an edge.
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Sender lean, receiver stalling for the directed rows and the first third.
		send_idle_pct  = 24;
		recv_stall_pct = 56;
		for (int i = 0; i < DIR_ROWS; i++)
			send_task_cmd(directed_rows[i].cmd, directed_rows[i].typed, directed_rows[i].status);

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == RANDOM_ITEMS / 3) begin
				// Swap: sender gappy, receiver mostly ready.
				send_idle_pct  = 56;
				recv_stall_pct = 24;
			end else if (i == 2 * RANDOM_ITEMS / 3) begin
				// Full rate on both sides.
				send_idle_pct  = 0;
				recv_stall_pct = 0;
			end
			send_task_cmd(random_task_cmd(), 1'b0, ST_OK);
		end
		s_tvalid <= 1'b0;

		// Drain the owed results, then let the block idle before the verdict.
		while (pending_replies.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0) begin
			$display("** priority_task_table_scheduler_core: PASSED **");
		end else begin
			$display("** priority_task_table_scheduler_core: FAILED **");
		end
		$finish;
	end

endmodule

FILE: sim.f
design/ptts_pkg.sv
design/ptts_cell.sv
design/priority_task_table_scheduler_core.sv
tb/sv/priority_task_table_scheduler_core_tb.sv
